// File: rtl/core/sobol_pkg.sv
// Shared types, constants and helpers for the Sobol sequence generator.
package sobol_pkg;

    localparam int FRACTION_BITS_DEF = 32;
    localparam int MAX_DEGREE_DEF    = 10;
    localparam int TABLE_DEPTH       = 32;
    localparam int TABLE_AW          = $clog2(TABLE_DEPTH);
    localparam int INIT_FIELDS       = 10;
    localparam int INIT_W            = 55;
    localparam int DEGREE_W          = 4;
    localparam int POLY_W            = 9;
    localparam int LEN_W             = 33;
    localparam int INDEX_W           = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 55;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDENTITY = 3'd0,
        REG_DEGREE   = 3'd1,
        REG_POLY     = 3'd2,
        REG_INIT     = 3'd3,
        REG_LENGTH   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic build_step;
        logic apply;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic built;
        logic build_last;
        logic can_advance;
        logic out_free;
    } status_t;

    // Initial number m_i (width i) from the packed field at bit i(i-1)/2; i = sel + 1.
    function automatic logic [INIT_FIELDS-1:0] init_field(
        input logic [INIT_W-1:0]   nums,
        input logic [TABLE_AW-1:0] sel
    );
        logic [INIT_FIELDS-1:0] m;
        m = '0;
        for (int j = 1; j <= INIT_FIELDS; j++)
        begin
            if (sel == TABLE_AW'(j - 1))
            begin
                for (int b = 0; b < j; b++)
                begin
                    m[b] = nums[j * (j - 1) / 2 + b];
                end
            end
        end
        return m;
    endfunction

    // Direction entry number minus one: trailing ones of the index, capped at the top.
    function automatic logic [TABLE_AW-1:0] dir_addr(input logic [INDEX_W-1:0] idx);
        logic [TABLE_AW-1:0] a;
        a = TABLE_AW'(TABLE_DEPTH - 1);
        for (int b = TABLE_DEPTH - 2; b >= 0; b--)
        begin
            if (!idx[b])
            begin
                a = TABLE_AW'(b);
            end
        end
        return a;
    endfunction

endpackage

// File: rtl/core/sobol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sobol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sobol_ctrl.sv
// Sequencing state machine for the Sobol sequence generator.
module sobol_ctrl
    import sobol_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    restart,
    input  status_t status,
    output logic    s_tready,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUILD = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.build_step = 1'b0;
        cmd.apply      = 1'b0;
        cmd.load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (restart || !status.built)
                    begin
                        state_next = ST_BUILD;
                    end
                    else if (status.can_advance)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_BUILD:
            begin
                cmd.build_step = 1'b1;
                if (status.build_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/sobol_dp.sv
// Datapath: configuration, direction table build, point update and output register.
module sobol_dp
    import sobol_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int MAX_DEGREE    = MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [INDEX_W-1:0]    point,
    output logic [INDEX_W-1:0]    index,
    output logic                  last
);

    logic                ident_reg;
    logic [DEGREE_W-1:0] degree_reg;
    logic [POLY_W-1:0]   poly_reg;
    logic [INIT_W-1:0]   init_reg;
    logic [LEN_W-1:0]    length_reg;

    logic [TABLE_AW-1:0]      cnt_reg;
    logic [FRACTION_BITS-1:0] win_reg [MAX_DEGREE];
    logic                     built_reg;
    logic [FRACTION_BITS-1:0] point_reg;
    logic [INDEX_W-1:0]       index_reg;

    logic                     out_valid_reg;
    logic [FRACTION_BITS-1:0] out_point_reg;
    logic [INDEX_W-1:0]       out_index_reg;
    logic                     out_last_reg;

    logic [DEGREE_W-1:0]      s_eff;
    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         idx_plus;
    logic [INIT_FIELDS-1:0]   m_val;
    logic [31:0]              v32;
    logic [FRACTION_BITS-1:0] base;
    logic [FRACTION_BITS-1:0] entry;
    logic [FRACTION_BITS-1:0] rdata;

    // Clamped degree and length
    always_comb
    begin
        if (degree_reg == '0)
        begin
            s_eff = DEGREE_W'(1);
        end
        else if (degree_reg > DEGREE_W'(MAX_DEGREE))
        begin
            s_eff = DEGREE_W'(MAX_DEGREE);
        end
        else
        begin
            s_eff = degree_reg;
        end
        if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (length_reg[LEN_W-1] && (length_reg[LEN_W-2:0] != '0))
        begin
            len_eff = {1'b1, {(LEN_W-1){1'b0}}};
        end
        else
        begin
            len_eff = length_reg;
        end
        idx_plus = {1'b0, index_reg} + LEN_W'(1);
    end

    // Direction entry cnt_reg + 1
    always_comb
    begin
        m_val = init_field(init_reg, cnt_reg);
        base  = '0;
        for (int t = 1; t <= MAX_DEGREE; t++)
        begin
            if (s_eff == DEGREE_W'(t))
            begin
                base = win_reg[t-1];
            end
        end
        if (ident_reg)
        begin
            v32   = 32'd1 << (TABLE_AW'(TABLE_DEPTH - 1) - cnt_reg);
            entry = v32[31 -: FRACTION_BITS];
        end
        else if ({1'b0, cnt_reg} < (TABLE_AW + 1)'(s_eff))
        begin
            v32   = {{(32 - INIT_FIELDS){1'b0}}, m_val} << (TABLE_AW'(TABLE_DEPTH - 1) - cnt_reg);
            entry = v32[31 -: FRACTION_BITS];
        end
        else
        begin
            v32   = '0;
            entry = base ^ (base >> s_eff);
            for (int k = 1; k < MAX_DEGREE; k++)
            begin
                for (int t = k + 1; t <= MAX_DEGREE; t++)
                begin
                    if ((s_eff == DEGREE_W'(t)) && poly_reg[t-1-k])
                    begin
                        entry = entry ^ win_reg[k-1];
                    end
                end
            end
        end
    end

    sobol_ram #(
        .WIDTH (FRACTION_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.build_step),
        .waddr (cnt_reg),
        .wdata (entry),
        .raddr (dir_addr(index_reg)),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg     <= 1'b1;
            degree_reg    <= DEGREE_W'(1);
            poly_reg      <= '0;
            init_reg      <= INIT_W'(1);
            length_reg    <= LEN_W'(1024);
            cnt_reg       <= '0;
            built_reg     <= 1'b0;
            point_reg     <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IDENTITY: ident_reg  <= cfg_data[0];
                    REG_DEGREE:   degree_reg <= cfg_data[DEGREE_W-1:0];
                    REG_POLY:     poly_reg   <= cfg_data[POLY_W-1:0];
                    REG_INIT:     init_reg   <= cfg_data[INIT_W-1:0];
                    REG_LENGTH:   length_reg <= cfg_data[LEN_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.build_step)
            begin
                cnt_reg <= cnt_reg + TABLE_AW'(1);
                if (status.build_last)
                begin
                    built_reg <= 1'b1;
                    point_reg <= '0;
                    index_reg <= '0;
                end
            end
            if (cmd.apply)
            begin
                point_reg <= point_reg ^ rdata;
                index_reg <= idx_plus[INDEX_W-1:0];
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_step)
        begin
            win_reg[0] <= entry;
            for (int k = 1; k < MAX_DEGREE; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        if (cmd.load_out)
        begin
            out_point_reg <= point_reg;
            out_index_reg <= index_reg;
            out_last_reg  <= (idx_plus >= len_eff);
        end
    end

    assign status.built       = built_reg;
    assign status.build_last  = (cnt_reg == TABLE_AW'(TABLE_DEPTH - 1));
    assign status.can_advance = (idx_plus < len_eff);
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign point    = INDEX_W'(out_point_reg);
    assign index    = out_index_reg;
    assign last     = out_last_reg;

endmodule

// File: rtl/core/sobol_sequence_generator.sv
// Top level of the one-dimension Sobol sequence generator.
// A restart item (or the first item after reset) rebuilds the 32-entry direction
// table, one entry per cycle, and then loads point 0 into the output register. An
// advance item reads its direction entry from a memory with a registered read,
// then one XOR updates the point before the result is loaded. Past the end of the
// sequence the result is loaded with the point and index unchanged. The block takes
// no new item until its result is loaded. The next item is accepted while a result
// waits in the output register; a stalled output holds the block before it loads
// the next result.
// Configuration takes effect for the table at the next rebuild.
module sobol_sequence_generator
    import sobol_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int MAX_DEGREE    = MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] restart
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // [31:0] point, [63:32] index
    output logic                  m_axis_tlast
);

    cmd_t                cmd;
    status_t             status;
    logic [INDEX_W-1:0]  point;
    logic [INDEX_W-1:0]  index;

    sobol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .restart  (s_axis_tdata[0]),
        .status   (status),
        .s_tready (s_axis_tready),
        .cmd      (cmd)
    );

    sobol_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_DEGREE    (MAX_DEGREE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .point     (point),
        .index     (index),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = {index, point};

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous one in progress");

    a_built_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        status.built |=> status.built)
        else $error("table built flag dropped");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.build_step && cmd.apply))
        else $error("build and apply at once");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the Sobol sequence generator: directed table, then random phases.
module tb
    import sobol_pkg::*;
();

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic [31:0] point;
        logic [31:0] index;
        logic        last;
    } sobol_result_t;

    typedef struct {
        bit            is_reg;
        cfg_reg_t      reg_sel;
        logic [54:0]   value;
        bit            restart;
        bit            typed;
        sobol_result_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    sobol_sequence_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // predictor state and its copy of the registers
    logic        cur_identity;
    logic [3:0]  cur_degree;
    logic [8:0]  cur_poly;
    logic [54:0] cur_init;
    logic [32:0] cur_len;
    logic [31:0] dir_tbl [TABLE_DEPTH];
    logic [31:0] cur_point;
    logic [32:0] cur_index;
    bit          tbl_ready;

    sobol_result_t pending_points [$];
    stim_row_t     dir_rows [$];
    int            errors = 0;
    int            items_sent;
    int            results_seen = 0;
    int            settings_used;
    logic [31:0]   deepest_index;
    int            burst_left;
    int            gap_left;
    int            quiet = 0;
    int            stall_mode = 0;
    int            stall_span = 0;

    function automatic void rebuild_directions();
        int          s;
        int          pos;
        logic [63:0] m;
        logic [31:0] v;
        logic [31:0] base;
        s = (cur_degree == 4'd0) ? 1 :
            (cur_degree > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(cur_degree);
        for (int i = 1; i <= TABLE_DEPTH; i++)
        begin
            if (cur_identity)
                v = 32'h1 << (32 - i);
            else if (i <= s)
            begin
                pos = i * (i - 1) / 2;
                m = ({9'b0, cur_init} >> pos) & ((64'h1 << i) - 64'h1);
                v = 32'(m << (32 - i));
            end
            else
            begin
                base = dir_tbl[i - s - 1];
                v = base ^ (base >> s);
                for (int k = 1; k < s; k++)
                    if (cur_poly[s - 1 - k])
                        v ^= dir_tbl[i - k - 1];
            end
            dir_tbl[i - 1] = v;
        end
        tbl_ready = 1'b1;
    endfunction

    function automatic sobol_result_t next_point(input logic restart);
        sobol_result_t r;
        logic [33:0]   n;
        logic [32:0]   t;
        int            c;
        n = {1'b0, cur_len};
        if (n == 34'd0)
            n = 34'd1;
        if (n > 34'h100000000)
            n = 34'h100000000;
        if (restart || !tbl_ready)
        begin
            rebuild_directions();
            cur_point = '0;
            cur_index = '0;
        end
        else if ({1'b0, cur_index} + 34'd1 < n)
        begin
            c = 1;
            t = cur_index;
            while (t[0] && c < TABLE_DEPTH)
            begin
                t = t >> 1;
                c++;
            end
            cur_point = cur_point ^ dir_tbl[c - 1];
            cur_index = cur_index + 33'd1;
        end
        r.point = cur_point;
        r.index = cur_index[31:0];
        r.last  = ({1'b0, cur_index} + 34'd1 >= n);
        return r;
    endfunction

    function automatic stim_row_t reg_row(input cfg_reg_t r, input logic [54:0] v);
        stim_row_t row;
        row.is_reg = 1'b1;
        row.reg_sel = r;
        row.value = v;
        row.restart = 1'b0;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t item_row(input bit restart, input bit typed,
                                           input logic [31:0] p, input logic [31:0] i,
                                           input logic l);
        stim_row_t row;
        row.is_reg = 1'b0;
        row.reg_sel = REG_IDENTITY;
        row.value = '0;
        row.restart = restart;
        row.typed = typed;
        row.want = '{point: p, index: i, last: l};
        return row;
    endfunction

    task automatic write_reg(input cfg_reg_t r, input logic [54:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        case (r)
            REG_IDENTITY: cur_identity = v[0];
            REG_DEGREE:   cur_degree = v[3:0];
            REG_POLY:     cur_poly = v[8:0];
            REG_INIT:     cur_init = v;
            REG_LENGTH:   cur_len = v[32:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(input bit restart, input bit typed, input sobol_result_t want);
        sobol_result_t r;
        while (gap_left > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            gap_left--;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, restart};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        r = next_point(restart);
        pending_points.push_back(typed ? want : r);
        items_sent++;
        if (r.index > deepest_index)
            deepest_index = r.index;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_span <= 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(5, 60);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= (stall_span % 8 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, point %h index %h last %b", $time,
                         m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
            end
            else
            begin
                if (m_axis_tdata[31:0] !== pending_points[0].point)
                begin
                    errors++;
                    $display("%0t: point mismatch, expected %h actual %h", $time,
                             pending_points[0].point, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[63:32] !== pending_points[0].index)
                begin
                    errors++;
                    $display("%0t: index mismatch, expected %h actual %h", $time,
                             pending_points[0].index, m_axis_tdata[63:32]);
                end
                if (m_axis_tlast !== pending_points[0].last)
                begin
                    errors++;
                    $display("%0t: last mismatch, expected %b actual %b", $time,
                             pending_points[0].last, m_axis_tlast);
                end
                void'(pending_points.pop_front());
            end
        end
    end

    // watchdog: cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no progress, %0d items still expected", $time,
                     pending_points.size());
            $display("sobol_sequence_generator regression: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   row;
        int          random_sent;
        int          phase_len;
        int          restart_rate;
        logic [32:0] len_pick;
        cur_identity = 1'b1;
        cur_degree = 4'd1;
        cur_poly = '0;
        cur_init = 55'd1;
        cur_len = 33'd1024;
        cur_point = '0;
        cur_index = '0;
        tbl_ready = 1'b0;
        items_sent = 0;
        settings_used = 1;
        deepest_index = '0;
        burst_left = 8;
        gap_left = 0;

        // advance before restart, identity steps, restart
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'h0, 32'd0, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'h80000000, 32'd1, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'hC0000000, 32'd2, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'h40000000, 32'd3, 1'b0));
        dir_rows.push_back(item_row(1'b1, 1'b1, 32'h0, 32'd0, 1'b0));
        // zero length taken as one
        dir_rows.push_back(reg_row(REG_LENGTH, 55'd0));
        dir_rows.push_back(item_row(1'b1, 1'b1, 32'h0, 32'd0, 1'b1));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'h0, 32'd0, 1'b1));
        // run past the end
        dir_rows.push_back(reg_row(REG_LENGTH, 55'd3));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'h80000000, 32'd1, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'hC0000000, 32'd2, 1'b1));
        dir_rows.push_back(item_row(1'b0, 1'b1, 32'hC0000000, 32'd2, 1'b1));
        // recurrence, degree zero, all-ones fields, oversize length
        dir_rows.push_back(reg_row(REG_IDENTITY, 55'd0));
        dir_rows.push_back(reg_row(REG_DEGREE, 55'd0));
        dir_rows.push_back(reg_row(REG_INIT, {55{1'b1}}));
        dir_rows.push_back(reg_row(REG_POLY, 55'h1FF));
        dir_rows.push_back(reg_row(REG_LENGTH, 55'h1FFFFFFFF));
        dir_rows.push_back(item_row(1'b1, 1'b1, 32'h0, 32'd0, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b0, '0, '0, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b0, '0, '0, 1'b0));
        // degree above the maximum
        dir_rows.push_back(reg_row(REG_DEGREE, 55'd15));
        dir_rows.push_back(item_row(1'b1, 1'b1, 32'h0, 32'd0, 1'b0));
        for (int n = 0; n < 4; n++)
            dir_rows.push_back(item_row(1'b0, 1'b0, '0, '0, 1'b0));
        // even initial numbers; old table stays until the next restart
        dir_rows.push_back(reg_row(REG_INIT, 55'd0));
        dir_rows.push_back(item_row(1'b0, 1'b0, '0, '0, 1'b0));
        dir_rows.push_back(item_row(1'b0, 1'b0, '0, '0, 1'b0));
        dir_rows.push_back(item_row(1'b1, 1'b0, '0, '0, 1'b0));
        for (int n = 0; n < 3; n++)
            dir_rows.push_back(item_row(1'b0, 1'b0, '0, '0, 1'b0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[n])
        begin
            row = dir_rows[n];
            if (row.is_reg)
            begin
                drain();
                write_reg(row.reg_sel, row.value);
                settings_used++;
            end
            else
                send_item(row.restart, row.typed, row.want);
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       len_pick = 33'd0;
                1:       len_pick = 33'h1FFFFFFFF;
                2:       len_pick = 33'h100000000;
                3:       len_pick = 33'({$urandom_range(0, 1), $urandom});
                default: len_pick = 33'($urandom_range(1, 40));
            endcase
            write_reg(REG_IDENTITY, 55'($urandom_range(0, 3) == 0));
            write_reg(REG_DEGREE, 55'($urandom_range(0, 15)));
            write_reg(REG_POLY, 55'($urandom_range(0, 511)));
            write_reg(REG_INIT, 55'({$urandom, $urandom}));
            write_reg(REG_LENGTH, 55'(len_pick));
            settings_used++;
            phase_len = $urandom_range(40, 300);
            restart_rate = $urandom_range(0, 1) ? 50 : 0;
            for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++)
            begin
                send_item((n == 0 && $urandom_range(0, 1)) ||
                          (restart_rate != 0 && $urandom_range(0, restart_rate - 1) == 0),
                          1'b0, '0);
                random_sent++;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("%0d items over %0d register settings, %0d results checked, %0d errors",
                 items_sent, settings_used, results_seen, errors);
        $display("deepest index reached: %0d", deepest_index);
        if (errors == 0)
            $display("sobol_sequence_generator regression: pass");
        else
            $display("sobol_sequence_generator regression: fail");
        $finish;
    end

endmodule
